// ===== rtl/core/gmc_pkg.sv =====
`default_nettype none

package gmc_pkg;

   // Number of vertices the block handles; rows, masks and counters follow from it.
   localparam int VERTICES = 15;
   localparam int IDX_W    = $clog2(VERTICES);
   localparam int K_W      = $clog2(VERTICES + 1);
   localparam int COUNT_W  = 7;
   localparam int CUT_W    = 8;

   typedef logic [VERTICES-1:0] row_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [K_W-1:0]      kcount_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [CUT_W-1:0]    cut_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WALK,
      ST_EMIT
   } state_type;

   // Write port of the adjacency store.
   typedef struct packed {
      logic    en;
      idx_type addr;
      row_type data;
   } adj_wr_type;

   function automatic kcount_type count_ones(row_type x);
      kcount_type n;
      n = '0;
      for (int i = 0; i < VERTICES; i++) begin
         n = n + kcount_type'(x[i]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gmc_if.sv =====
`default_nettype none

interface gmc_req_if;
   logic              valid;
   logic              ready;
   gmc_pkg::idx_type  vertex;
   gmc_pkg::row_type  neighbors;
   gmc_pkg::row_type  active;
   logic              last;

   modport source(output valid, output vertex, output neighbors, output active,
                  output last, input ready);
   modport sink(input valid, input vertex, input neighbors, input active,
                input last, output ready);
endinterface

interface gmc_rsp_if;
   logic                valid;
   logic                ready;
   gmc_pkg::count_type  max_cut;
   gmc_pkg::count_type  edge_count;
   gmc_pkg::count_type  beta;

   modport source(output valid, output max_cut, output edge_count, output beta,
                  input ready);
   modport sink(input valid, input max_cut, input edge_count, input beta,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gmc_adj_store.sv =====
`default_nettype none

// Adjacency rows held in flip-flops; reset clears every row.
module gmc_adj_store (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire gmc_pkg::adj_wr_type wr,
   input  wire gmc_pkg::idx_type    rd_addr,
   output gmc_pkg::row_type         rd_data
);

   gmc_pkg::row_type rows_ff [gmc_pkg::VERTICES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gmc_pkg::VERTICES; i++) begin
            rows_ff[i] <= '0;
         end
      end else if (wr.en && (32'(wr.addr) < gmc_pkg::VERTICES)) begin
         rows_ff[wr.addr] <= wr.data;
      end
   end

   assign rd_data = rows_ff[rd_addr];

endmodule

`default_nettype wire

// ===== rtl/core/graph_max_cut_bruteforce.sv =====
`default_nettype none

// Exhaustive maximum cut of a graph of up to 15 vertices. Each request carries
// one adjacency row, which is stored under its vertex index (indices of 15 and
// above are not stored). A request marked last stores its row, then starts a
// computation over the vertices selected by its active mask and later yields
// one response holding the maximum cut, the number of edges among the active
// vertices and their difference (beta). For an active pair v < w the edge is
// taken from bit w of row v only; self loops are ignored. After accepting a
// last request the block scans the stored rows (one row per cycle through the
// store's single read port, building a symmetric neighbor table of the active
// vertices and counting edges), then walks all colorings of the k active
// vertices in Gray-code order, one vertex flip per cycle, and then loads the
// response register. The load waits while the previous response is still
// held in the response register, so a slow consumer delays it. The block
// takes no request while computing; it accepts plain rows again as soon as
// the response register is loaded, even before that response is taken.
module graph_max_cut_bruteforce (
   input wire logic  clock,
   input wire logic  reset,
   gmc_req_if.sink   req_ch,
   gmc_rsp_if.source rsp_ch
);

   localparam int V = gmc_pkg::VERTICES;

   gmc_pkg::state_type  state_ff, state_in;
   gmc_pkg::idx_type    idx_ff, idx_in;
   gmc_pkg::kcount_type k_ff, k_in;
   gmc_pkg::row_type    active_ff, active_in;
   gmc_pkg::row_type    sym_ff [V];
   gmc_pkg::row_type    sym_in [V];
   gmc_pkg::idx_type    list_ff [V];
   gmc_pkg::idx_type    list_in [V];
   gmc_pkg::row_type    coloring_ff, coloring_in;
   gmc_pkg::cut_type    cut_ff, cut_in;
   gmc_pkg::cut_type    best_ff, best_in;
   gmc_pkg::row_type    gray_ff, gray_in;
   gmc_pkg::count_type  edges_ff, edges_in;
   logic                rsp_valid_ff, rsp_valid_in;
   gmc_pkg::count_type  rsp_max_ff, rsp_max_in;
   gmc_pkg::count_type  rsp_edges_ff, rsp_edges_in;
   gmc_pkg::count_type  rsp_beta_ff, rsp_beta_in;

   gmc_pkg::adj_wr_type adj_wr;
   gmc_pkg::row_type    adj_row;
   logic                req_accept;

   // Scan and walk datapath signals.
   gmc_pkg::row_type    above;
   gmc_pkg::row_type    hits;
   gmc_pkg::idx_type    flip_pos;
   gmc_pkg::idx_type    flip_vertex;
   gmc_pkg::row_type    nb;
   gmc_pkg::row_type    same;
   gmc_pkg::kcount_type gain;
   gmc_pkg::kcount_type degree;
   gmc_pkg::cut_type    next_cut;
   gmc_pkg::row_type    walk_full;

   // Position of the lowest set bit; the argument is never zero in the walk.
   function automatic gmc_pkg::idx_type lowest_set(gmc_pkg::row_type x);
      gmc_pkg::idx_type r;
      r = '0;
      for (int i = V - 1; i >= 0; i--) begin
         if (x[i]) begin
            r = gmc_pkg::idx_type'(i);
         end
      end
      return r;
   endfunction

   assign req_ch.ready = (state_ff == gmc_pkg::ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.max_cut    = rsp_max_ff;
   assign rsp_ch.edge_count = rsp_edges_ff;
   assign rsp_ch.beta       = rsp_beta_ff;

   // Every accepted request writes its row; the scan reads one row per cycle.
   assign adj_wr.en   = req_accept;
   assign adj_wr.addr = req_ch.vertex;
   assign adj_wr.data = req_ch.neighbors;

   gmc_adj_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (adj_wr),
      .rd_addr (idx_ff),
      .rd_data (adj_row)
   );

   // Edges of the current row that go to higher-numbered active vertices.
   assign above = (gmc_pkg::row_type'({V{1'b1}}) << idx_ff) << 1;
   assign hits  = adj_row & active_ff & above;

   // One Gray-code flip: the lowest set bit of the step counter selects the
   // compact index, which maps back to the real vertex through the list.
   // The cut changes by (same-color neighbors) - (other-color neighbors),
   // which equals twice the same-color count minus the degree.
   assign flip_pos    = lowest_set(gray_ff);
   assign flip_vertex = list_ff[flip_pos];
   assign nb          = sym_ff[flip_vertex];
   assign same        = coloring_ff[flip_vertex] ? coloring_ff : (~coloring_ff & active_ff);
   assign gain        = gmc_pkg::count_ones(nb & same);
   assign degree      = gmc_pkg::count_ones(nb);
   assign next_cut    = cut_ff + gmc_pkg::cut_type'({gain, 1'b0})
                        - gmc_pkg::cut_type'(degree);
   assign walk_full   = ~(gmc_pkg::row_type'({V{1'b1}}) << k_ff);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      active_in    = active_ff;
      sym_in       = sym_ff;
      list_in      = list_ff;
      coloring_in  = coloring_ff;
      cut_in       = cut_ff;
      best_in      = best_ff;
      gray_in      = gray_ff;
      edges_in     = edges_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_max_in   = rsp_max_ff;
      rsp_edges_in = rsp_edges_ff;
      rsp_beta_in  = rsp_beta_ff;

      unique case (state_ff)
         gmc_pkg::ST_IDLE: begin
            if (req_accept && req_ch.last) begin
               active_in = req_ch.active;
               idx_in    = '0;
               k_in      = '0;
               edges_in  = '0;
               for (int i = 0; i < V; i++) begin
                  sym_in[i] = '0;
               end
               state_in = gmc_pkg::ST_SCAN;
            end
         end

         gmc_pkg::ST_SCAN: begin
            if (active_ff[idx_ff]) begin
               list_in[k_ff[gmc_pkg::IDX_W-1:0]] = idx_ff;
               k_in     = k_ff + 1'b1;
               edges_in = edges_ff + gmc_pkg::count_type'(gmc_pkg::count_ones(hits));
               sym_in[idx_ff] = sym_ff[idx_ff] | hits;
               for (int w = 0; w < V; w++) begin
                  if (hits[w]) begin
                     sym_in[w][idx_ff] = 1'b1;
                  end
               end
            end
            if (32'(idx_ff) == V - 1) begin
               gray_in     = gmc_pkg::row_type'(1);
               coloring_in = '0;
               cut_in      = '0;
               best_in     = '0;
               // With no active vertex the result is all zero.
               if (k_in == '0) begin
                  state_in = gmc_pkg::ST_EMIT;
               end else begin
                  state_in = gmc_pkg::ST_WALK;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         gmc_pkg::ST_WALK: begin
            cut_in      = next_cut;
            coloring_in = coloring_ff ^ (gmc_pkg::row_type'(1) << flip_vertex);
            if (next_cut > best_ff) begin
               best_in = next_cut;
            end
            if (gray_ff == walk_full) begin
               state_in = gmc_pkg::ST_EMIT;
            end else begin
               gray_in = gray_ff + 1'b1;
            end
         end

         gmc_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = best_ff[gmc_pkg::COUNT_W-1:0];
               rsp_edges_in = edges_ff;
               rsp_beta_in  = edges_ff - best_ff[gmc_pkg::COUNT_W-1:0];
               state_in     = gmc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = gmc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gmc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      k_ff         <= k_in;
      active_ff    <= active_in;
      sym_ff       <= sym_in;
      list_ff      <= list_in;
      coloring_ff  <= coloring_in;
      cut_ff       <= cut_in;
      best_ff      <= best_in;
      gray_ff      <= gray_in;
      edges_ff     <= edges_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_edges_ff <= rsp_edges_in;
      rsp_beta_ff  <= rsp_beta_in;
   end

endmodule

`default_nettype wire
